>>> rtl/mclp_pkg.sv
// ----------------------------------------------------------------------------
// mclp_pkg
// Shared types, constants and helpers for the multi-click / long-press
// button detector.
// ----------------------------------------------------------------------------
package mclp_pkg;

  // field and register widths
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned SHORT_W  = 3;
  localparam int unsigned LONG_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = WIN_W;

  // reset values of the configuration registers
  localparam logic [WIN_W-1:0] WINDOW_TICKS_RST   = WIN_W'(100);
  localparam logic [THR_W-1:0] LONG_THRESHOLD_RST = THR_W'(20);

  // largest reported counts
  localparam logic [CNT_W-1:0] SHORT_MAX = CNT_W'(5);
  localparam logic [CNT_W-1:0] LONG_MAX  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_SAT   = {CNT_W{1'b1}};
  localparam logic [WIN_W-1:0] WIN_SAT   = {WIN_W{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_TICKS   = 1'b0,
    CFG_LONG_THRESHOLD = 1'b1
  } cfg_idx_t;

  // configuration seen by the detector core
  typedef struct packed {
    logic [WIN_W-1:0] window_ticks;
    logic [THR_W-1:0] long_threshold;
  } cfg_t;

  // one result transaction
  typedef struct packed {
    logic               window_closed;
    logic [SHORT_W-1:0] short_clicks;
    logic [LONG_W-1:0]  long_presses;
    logic               long_release;
  } result_t;

  // saturating increment of an event count
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_SAT) ? v : v + CNT_W'(1);
  endfunction

endpackage

>>> rtl/multi_click_long_press_detector.sv
// ----------------------------------------------------------------------------
// multi_click_long_press_detector
// Counts short clicks and long presses of a button inside an analysis window.
// ----------------------------------------------------------------------------
// One input transaction is one scan tick with the button level, and each one
// yields exactly one result transaction. The block takes a tick every clock
// cycle while in_stall is low; a tick passes the input register, then the
// result register, and a new tick can enter while the previous result is still
// stalled. The window length (index 0, default 100 ticks) and the long-press
// threshold (index 1, default 20 ticks) must be written through the cfg port
// only while no tick is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module multi_click_long_press_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  // scan tick input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_button_pressed,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_window_closed,
  output logic [mclp_pkg::SHORT_W-1:0]   out_short_clicks,
  output logic [mclp_pkg::LONG_W-1:0]    out_long_presses,
  output logic                           out_long_release,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mclp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mclp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mclp_pkg::*;

  cfg_t    cfg_r;
  logic    s1_valid_r, s1_valid_nxt;
  logic    s1_pressed_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t core_res;
  logic    in_take, advance;

  // configuration register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks   <= WINDOW_TICKS_RST;
      cfg_r.long_threshold <= LONG_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WINDOW_TICKS:   cfg_r.window_ticks   <= cfg_data[WIN_W-1:0];
        CFG_LONG_THRESHOLD: cfg_r.long_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pressed_r <= in_button_pressed;
    end
  end

  // detector state and per-tick result
  mclp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .pressed (s1_pressed_r),
    .cfg     (cfg_r),
    .res     (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_window_closed = out_res_r.window_closed;
  assign out_short_clicks  = out_res_r.short_clicks;
  assign out_long_presses  = out_res_r.long_presses;
  assign out_long_release  = out_res_r.long_release;

endmodule

>>> rtl/mclp_core.sv
// ----------------------------------------------------------------------------
// mclp_core
// Scanner and analysis window state. One scan tick is applied per cycle in
// which step is high; the result for that tick is available combinationally.
// ----------------------------------------------------------------------------
module mclp_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             pressed,
  input  mclp_pkg::cfg_t   cfg,
  output mclp_pkg::result_t res
);
  import mclp_pkg::*;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_LONG     = 2'd2
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [THR_W-1:0]   hold_r, hold_nxt;
  logic               win_open_r, win_open_nxt;
  logic [WIN_W-1:0]   elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]   short_r, short_nxt;
  logic [CNT_W-1:0]   long_r, long_nxt;

  logic [WIN_W-1:0]   elapsed_inc;
  logic               closing;
  logic [CNT_W-1:0]   short_mid, long_mid;
  logic               win_open_mid;
  logic [WIN_W-1:0]   elapsed_mid;
  logic               lrel;

  // window timer runs first
  always_comb begin
    elapsed_inc  = (elapsed_r != WIN_SAT) ? elapsed_r + WIN_W'(1) : elapsed_r;
    closing      = win_open_r && (elapsed_inc >= cfg.window_ticks);
    short_mid    = closing ? '0 : short_r;
    long_mid     = closing ? '0 : long_r;
    win_open_mid = closing ? 1'b0 : win_open_r;
    elapsed_mid  = closing ? '0 : (win_open_r ? elapsed_inc : elapsed_r);
  end

  // press scanner on this tick's level
  always_comb begin
    phase_nxt    = phase_r;
    hold_nxt     = hold_r;
    short_nxt    = short_mid;
    long_nxt     = long_mid;
    win_open_nxt = win_open_mid;
    elapsed_nxt  = elapsed_mid;
    lrel         = 1'b0;
    unique case (phase_r)
      PH_PRESSED: begin
        if (pressed) begin
          if (hold_r < cfg.long_threshold) begin
            hold_nxt = hold_r + THR_W'(1);
          end else begin
            phase_nxt = PH_LONG;
            hold_nxt  = '0;
            long_nxt  = sat_inc(long_mid);
          end
        end else begin
          phase_nxt = PH_RELEASED;
          hold_nxt  = '0;
          short_nxt = sat_inc(short_mid);
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          phase_nxt = PH_RELEASED;
          hold_nxt  = '0;
          lrel      = 1'b1;
        end
      end
      default: begin
        // released, and the unused code behaves the same
        if (pressed) begin
          phase_nxt = PH_PRESSED;
          hold_nxt  = '0;
          if (!win_open_mid) begin
            win_open_nxt = 1'b1;
            elapsed_nxt  = '0;
          end
        end else begin
          phase_nxt = PH_RELEASED;
        end
      end
    endcase
  end

  // result fields for this tick
  always_comb begin
    res.window_closed = closing;
    res.short_clicks  = (closing && short_r != '0 && short_r <= SHORT_MAX)
                        ? short_r[SHORT_W-1:0] : '0;
    res.long_presses  = (closing && long_r != '0 && long_r <= LONG_MAX)
                        ? long_r[LONG_W-1:0] : '0;
    res.long_release  = lrel;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_RELEASED;
      hold_r     <= '0;
      win_open_r <= 1'b0;
      elapsed_r  <= '0;
      short_r    <= '0;
      long_r     <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      hold_r     <= hold_nxt;
      win_open_r <= win_open_nxt;
      elapsed_r  <= elapsed_nxt;
      short_r    <= short_nxt;
      long_r     <= long_nxt;
    end
  end

endmodule

>>> rtl/mclp_checker.sv
// ----------------------------------------------------------------------------
// mclp_checker
// Port-level checks for the button detector, bound to the top level.
// ----------------------------------------------------------------------------
module mclp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            in_button_pressed,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_window_closed,
  input logic [mclp_pkg::SHORT_W-1:0]    out_short_clicks,
  input logic [mclp_pkg::LONG_W-1:0]     out_long_presses,
  input logic                            out_long_release,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [mclp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [mclp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mclp_pkg::*;

  logic prev_lrel_r;

  // long release flag of the last delivered transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_lrel_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      prev_lrel_r <= out_long_release;
    end
  end

  // counts are reported only on the tick the window closes
  a_counts_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_closed |-> out_short_clicks == '0 && out_long_presses == '0)
    else $error("counts reported without window close");

  // reported counts stay within their ranges
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_short_clicks <= SHORT_W'(5) && out_long_presses != LONG_W'(3))
    else $error("reported count out of range");

  // a long release cannot follow another long release directly
  a_no_double_lrel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && prev_lrel_r |-> !out_long_release)
    else $error("two long releases in consecutive transactions");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_window_closed)
      && $stable(out_short_clicks) && $stable(out_long_presses)
      && $stable(out_long_release))
    else $error("stalled result changed");

endmodule

bind multi_click_long_press_detector mclp_checker u_mclp_checker (.*);
